// File: hdl/sesc_pkg.sv
`default_nettype none
package sesc_pkg;

  // default line store depth (pixels per row)
  localparam int MAX_COLS_DEF = 1024;

  // field widths
  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int COLS_W = 11;
  localparam int ROWS_W = 12;
  localparam int KSQ_W  = 40;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_KSQ  = 2'd2
  } cfg_reg_e;

  // register reset values
  localparam logic [COLS_W-1:0] COLS_RST = 11'd640;
  localparam logic [ROWS_W-1:0] ROWS_RST = 12'd480;
  localparam logic [KSQ_W-1:0]  KSQ_RST  = 40'd6553600;

  // gradient path widths: a Sobel half-sum is below 4 * 2^16
  localparam int GRAD_W = PIX_W + 2;
  localparam int GSQ_W  = 2 * GRAD_W + 1;
  localparam int DEN_W  = KSQ_W + 1;
  // quotient never exceeds 2^16, so 17 bits, one per divider step
  localparam int QUO_W  = COEF_W + 1;
  localparam int REM_W  = DEN_W + COEF_W;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'(QUO_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQ,
    S_DINIT,
    S_DIV,
    S_EMIT
  } state_e;

endpackage
`default_nettype wire

// File: hdl/sesc_ram.sv
`default_nettype none
module sesc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/sobel_edge_stopping_coefficient.sv
`default_nettype none
// An accepted interior pixel passes line store read, gradient, square, divider setup,
// 17-step divider and emit on its way to the output register; a border pixel goes from
// the line store read to emit, and a flush giving a tail result goes straight to emit.
// One item at a time: a new item is taken only once the last one is through, and later
// while the result side stalls. Reset (async, active low) restores positions, tail count,
// window and registers to their defaults; line store contents stay undefined until written.
module sobel_edge_stopping_coefficient #(
  parameter int MAX_COLS = sesc_pkg::MAX_COLS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [sesc_pkg::PIX_W-1:0]      s_axis_tdata_i,  // [15:0] pixel
  input  wire logic                            s_axis_tuser_i,  // [0] kind (1 = flush)
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [sesc_pkg::COEF_W-1:0]     m_axis_tdata_o,  // [15:0] coefficient
  output logic                                 m_axis_tlast_o,  // frame_end
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [sesc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sesc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int EW = $clog2(MAX_COLS + 1);
  localparam int PW = $clog2(MAX_COLS + 2);
  localparam int LW = 2 * sesc_pkg::PIX_W;
  localparam logic [31:0] MaxCols32 = 32'(MAX_COLS);

  localparam int RW = sesc_pkg::ROWS_W;
  localparam int GW = sesc_pkg::GRAD_W;

  // configuration registers
  logic [sesc_pkg::COLS_W-1:0] cols_q;
  logic [RW-1:0]               rows_q;
  logic [sesc_pkg::KSQ_W-1:0]  ksq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= sesc_pkg::COLS_RST;
      rows_q <= sesc_pkg::ROWS_RST;
      ksq_q  <= sesc_pkg::KSQ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sesc_pkg::CFG_COLS: cols_q <= cfg_data_i[sesc_pkg::COLS_W-1:0];
        sesc_pkg::CFG_ROWS: rows_q <= cfg_data_i[RW-1:0];
        sesc_pkg::CFG_KSQ:  ksq_q  <= cfg_data_i[sesc_pkg::KSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  sesc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic [AW-1:0]   cpos_q, cpos_d;
  logic [RW-1:0]   rpos_q, rpos_d;
  logic [PW-1:0]   pend_q, pend_d;
  logic [15:0]     win_q [9];
  logic [15:0]     win_d [9];

  // datapath
  logic [sesc_pkg::PIX_W-1:0]  px_q, px_d;
  logic [AW-1:0]               c_q, c_d;
  logic                        emit_q, emit_d;
  logic                        border_q, border_d;
  logic [GW-1:0]               ax_q, ax_d, ay_q, ay_d;
  logic [sesc_pkg::GSQ_W-1:0]  g_q, g_d;
  logic [sesc_pkg::REM_W-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic                        dz_q, dz_d;
  logic [sesc_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [sesc_pkg::QUO_W-1:0]  quot_q, quot_d;
  logic [sesc_pkg::COEF_W-1:0] res_coef_q, res_coef_d, out_coef_q, out_coef_d;
  logic                        res_last_q, res_last_d, out_last_q, out_last_d;

  // line stores: upper in the high half, middle in the low half
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_wdata, ram_rdata;

  sesc_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective frame geometry
  logic [EW-1:0] eff_cols;
  logic [RW-1:0] eff_rows;
  logic [AW-1:0] c_now;
  logic          last_col, last_row;

  always_comb begin
    if (cols_q == '0) begin
      eff_cols = EW'(1);
    end else if (32'(cols_q) > MaxCols32) begin
      eff_cols = EW'(MAX_COLS);
    end else begin
      eff_cols = EW'(cols_q);
    end
    eff_rows = (rows_q == '0) ? RW'(1) : rows_q;
    c_now    = (EW'(cpos_q) >= eff_cols) ? AW'(eff_cols - EW'(1)) : cpos_q;
    last_col = (EW'(c_now) + EW'(1)) >= eff_cols;
    last_row = ({1'b0, rpos_q} + (RW + 1)'(1)) >= {1'b0, eff_rows};
  end

  // Sobel half sums from the window
  logic [GW-1:0] sxp, sxn, syp, syn;
  always_comb begin
    sxp = GW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + GW'(win_q[8]);
    sxn = GW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + GW'(win_q[6]);
    syp = GW'(win_q[6]) + {1'b0, win_q[7], 1'b0} + GW'(win_q[8]);
    syn = GW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + GW'(win_q[2]);
  end

  // squared gradient magnitudes, full product width
  logic [2*GW-1:0] axsq, aysq;
  always_comb begin
    axsq = ax_q * ax_q;
    aysq = ay_q * ay_q;
  end

  // one restoring divider step
  logic                       div_ge;
  logic [sesc_pkg::QUO_W-1:0] quot_n;
  logic [sesc_pkg::DEN_W-1:0] den;
  always_comb begin
    div_ge = rem_q >= dvs_q;
    quot_n = {quot_q[sesc_pkg::QUO_W-2:0], div_ge};
    den    = {1'b0, ksq_q} + sesc_pkg::DEN_W'(g_q);
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cpos_d      = cpos_q;
    rpos_d      = rpos_q;
    pend_d      = pend_q;
    win_d       = win_q;
    px_d        = px_q;
    c_d         = c_q;
    emit_d      = emit_q;
    border_d    = border_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    g_d         = g_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    dz_d        = dz_q;
    cnt_d       = cnt_q;
    quot_d      = quot_q;
    res_coef_d  = res_coef_q;
    res_last_d  = res_last_q;
    out_coef_d  = out_coef_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_raddr   = c_now;
    ram_wdata   = {ram_rdata[sesc_pkg::PIX_W-1:0], px_q};
    s_axis_tready_o = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sesc_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i) begin
            // flush: hand out one owed tail result
            if (pend_q != '0) begin
              res_coef_d = '0;
              res_last_d = (pend_q == PW'(1));
              pend_d     = pend_q - PW'(1);
              state_d    = sesc_pkg::S_EMIT;
            end
          end else begin
            px_d     = s_axis_tdata_i;
            c_d      = c_now;
            emit_d   = (rpos_q >= RW'(2)) || (rpos_q == RW'(1) && c_now != '0);
            border_d = (c_now == AW'(0)) || (c_now == AW'(1)) ||
                       (rpos_q == RW'(1)) || (rpos_q >= eff_rows);
            pend_d   = '0;
            if (last_col) begin
              cpos_d = '0;
              if (last_row) begin
                rpos_d = '0;
                pend_d = PW'(eff_cols) + ((eff_rows == RW'(1)) ? PW'(0) : PW'(1));
              end else begin
                rpos_d = rpos_q + RW'(1);
              end
            end else begin
              cpos_d = AW'(EW'(c_now) + EW'(1));
            end
            state_d = sesc_pkg::S_READ;
          end
        end
      end
      sesc_pkg::S_READ: begin
        // line store data is out: shift the window, write back
        ram_we   = 1'b1;
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = ram_rdata[LW-1:sesc_pkg::PIX_W];
        win_d[3] = win_q[4];
        win_d[4] = win_q[5];
        win_d[5] = ram_rdata[sesc_pkg::PIX_W-1:0];
        win_d[6] = win_q[7];
        win_d[7] = win_q[8];
        win_d[8] = px_q;
        if (!emit_q) begin
          state_d = sesc_pkg::S_IDLE;
        end else if (border_q) begin
          res_coef_d = '0;
          res_last_d = 1'b0;
          state_d    = sesc_pkg::S_EMIT;
        end else begin
          state_d = sesc_pkg::S_GRAD;
        end
      end
      sesc_pkg::S_GRAD: begin
        ax_d    = (sxp >= sxn) ? sxp - sxn : sxn - sxp;
        ay_d    = (syp >= syn) ? syp - syn : syn - syp;
        state_d = sesc_pkg::S_SQ;
      end
      sesc_pkg::S_SQ: begin
        g_d     = sesc_pkg::GSQ_W'(axsq) + sesc_pkg::GSQ_W'(aysq);
        state_d = sesc_pkg::S_DINIT;
      end
      sesc_pkg::S_DINIT: begin
        rem_d   = {1'b0, ksq_q, {sesc_pkg::COEF_W{1'b0}}};
        dvs_d   = {den, {sesc_pkg::COEF_W{1'b0}}};
        dz_d    = (den == '0);
        cnt_d   = sesc_pkg::DIV_LAST;
        quot_d  = '0;
        state_d = sesc_pkg::S_DIV;
      end
      sesc_pkg::S_DIV: begin
        rem_d  = div_ge ? rem_q - dvs_q : rem_q;
        dvs_d  = dvs_q >> 1;
        quot_d = quot_n;
        cnt_d  = cnt_q - sesc_pkg::CNT_W'(1);
        if (cnt_q == '0) begin
          // saturate 1.0 to all ones; zero denominator gives zero
          if (dz_q) begin
            res_coef_d = '0;
          end else if (quot_n[sesc_pkg::QUO_W-1]) begin
            res_coef_d = '1;
          end else begin
            res_coef_d = quot_n[sesc_pkg::COEF_W-1:0];
          end
          res_last_d = 1'b0;
          state_d    = sesc_pkg::S_EMIT;
        end
      end
      sesc_pkg::S_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_coef_d  = res_coef_q;
          out_last_d  = res_last_q;
          state_d     = sesc_pkg::S_IDLE;
        end
      end
      default: state_d = sesc_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sesc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      cpos_q      <= '0;
      rpos_q      <= '0;
      pend_q      <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cpos_q      <= cpos_d;
      rpos_q      <= rpos_d;
      pend_q      <= pend_d;
      win_q       <= win_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    c_q        <= c_d;
    emit_q     <= emit_d;
    border_q   <= border_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    g_q        <= g_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    dz_q       <= dz_d;
    cnt_q      <= cnt_d;
    quot_q     <= quot_d;
    res_coef_q <= res_coef_d;
    res_last_q <= res_last_d;
    out_coef_q <= out_coef_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_coef_q;
  assign m_axis_tlast_o  = out_last_q;

  // checks
  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o == '0)
    else $error("frame end carries a nonzero coefficient");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= MaxCols32 + 32'd1)
    else $error("tail count beyond one row plus one");

  a_pixel_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=> state_q == sesc_pkg::S_READ)
    else $error("pixel accepted without a line store access");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sesc_pkg::S_DIV |-> cnt_q <= sesc_pkg::DIV_LAST)
    else $error("divider step count out of range");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sesc_pkg::S_DIV && dz_q |-> ksq_q == '0 && g_q == '0)
    else $error("zero denominator with nonzero operands");

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

// One expected weight: coefficient plus its frame_end flag
typedef struct {
  logic [15:0] coef;
  logic        last;
} weight_item_t;

// Tracks the line stores, window and frame position, and queues the weights due
class weight_scoreboard;
  logic [10:0] cols_reg;
  logic [11:0] rows_reg;
  logic [39:0] ksq_reg;
  logic [15:0] row_above [sesc_pkg::MAX_COLS_DEF];
  logic [15:0] row_mid [sesc_pkg::MAX_COLS_DEF];
  logic [15:0] win [9];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned tail_owed;
  weight_item_t weights_due [$];
  int unsigned live_items;
  int unsigned weights_seen;
  int unsigned frames_done;
  int unsigned mismatches;

  function new();
    cols_reg = sesc_pkg::COLS_RST;
    rows_reg = sesc_pkg::ROWS_RST;
    ksq_reg  = sesc_pkg::KSQ_RST;
    foreach (row_above[i]) begin
      row_above[i] = '0;
      row_mid[i]   = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    tail_owed = 0;
    live_items = 0;
    weights_seen = 0;
    frames_done = 0;
    mismatches = 0;
  endfunction

  // out-of-range column counts clamp to 1..MAX_COLS
  function int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > sesc_pkg::MAX_COLS_DEF) return sesc_pkg::MAX_COLS_DEF;
    return cols_reg;
  endfunction

  function int unsigned eff_rows();
    return (rows_reg == 0) ? 1 : rows_reg;
  endfunction

  function void write_reg(sesc_pkg::cfg_reg_e idx, logic [39:0] val);
    case (idx)
      sesc_pkg::CFG_COLS: cols_reg = val[10:0];
      sesc_pkg::CFG_ROWS: rows_reg = val[11:0];
      sesc_pkg::CFG_KSQ:  ksq_reg  = val;
      default: ;
    endcase
  endfunction

  // Called once per accepted item; queues the weight it releases, if any
  function void accept_item(logic flush, logic [15:0] px);
    int unsigned cols, rows, c, r, orow, ocol;
    longint gx, gy;
    longint unsigned g, den, q, ku;
    logic [15:0] up, mid;
    weight_item_t e;
    cols = eff_cols();
    rows = eff_rows();
    // flush: drain one tail weight, or nothing when none is owed
    if (flush) begin
      if (tail_owed == 0) return;
      e.coef = '0;
      e.last = (tail_owed == 1);
      weights_due = {weights_due, e};
      tail_owed--;
      live_items++;
      return;
    end
    live_items++;
    // a pixel drops any tail still owed
    tail_owed = 0;
    c = col_pos;
    r = row_pos;
    if (c >= cols) c = cols - 1;
    up  = row_above[c];
    mid = row_mid[c];
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    row_above[c] = mid;
    row_mid[c]   = px;
    // weight of the window center, one row and one column back
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c >= 1) begin
        orow = r - 1;
        ocol = c - 1;
      end else begin
        orow = r - 2;
        ocol = cols - 1;
      end
      e.coef = '0;
      e.last = 1'b0;
      if (!(orow == 0 || orow + 1 >= rows || ocol == 0 || ocol + 1 >= cols)) begin
        gx = (longint'(win[2]) + 2 * longint'(win[5]) + longint'(win[8]))
           - (longint'(win[0]) + 2 * longint'(win[3]) + longint'(win[6]));
        gy = (longint'(win[6]) + 2 * longint'(win[7]) + longint'(win[8]))
           - (longint'(win[0]) + 2 * longint'(win[1]) + longint'(win[2]));
        g  = gx * gx + gy * gy;
        ku = ksq_reg;
        den = ku + g;
        // zero threshold on a flat window leaves weight 0
        if (den != 0) begin
          q = (ku << 16) / den;
          e.coef = (q > 65535) ? 16'hFFFF : q[15:0];
        end
      end
      weights_due = {weights_due, e};
    end
    // advance the raster position; frame end arms the tail
    if (c + 1 >= cols) begin
      col_pos = 0;
      if (r + 1 >= rows) begin
        row_pos = 0;
        tail_owed = (rows == 1) ? cols : cols + 1;
        frames_done++;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] weight mismatch: %s", $time, msg);
  endtask

  task compare_weight(logic [15:0] coef, logic last);
    weight_item_t e;
    if (weights_due.size() == 0) begin
      report($sformatf("unexpected weight %h frame_end %b", coef, last));
      return;
    end
    e = weights_due.pop_front();
    weights_seen++;
    if (coef !== e.coef)
      report($sformatf("weight #%0d coefficient %h, want %h", weights_seen, coef, e.coef));
    if (last !== e.last)
      report($sformatf("weight #%0d frame_end %b, want %b", weights_seen, last, e.last));
  endtask
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 900;

  // 4x4 frame: checkerboard, step edges and odd bit patterns
  localparam logic [15:0] EDGE_FRAME [16] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
    16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
    16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
    16'h1234, 16'h8000, 16'h7FFF, 16'h0001
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [sesc_pkg::PIX_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [sesc_pkg::COEF_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [sesc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sesc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  weight_scoreboard sb = new();
  bit calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned setting_count = 0;

  sobel_edge_stopping_coefficient i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // result side: random backpressure unless in a calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.compare_weight(m_axis_tdata, m_axis_tlast);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d weights outstanding",
               cycle_count, sb.weights_due.size());
      $display("** sobel_edge_stopping_coefficient: FAILED **");
      $finish;
    end
  end

  // Drive one item, with an occasional gap first; flush items carry random data
  task automatic send_item(logic flush, logic [15:0] px);
    logic [15:0] word;
    word = flush ? 16'($urandom) : px;
    if (!calm && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= flush;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_item(flush, word);
  endtask

  // Hold the input until every expected weight is out, then let the pipe settle
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.weights_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves the write enable high; caller lowers it after the last write
  task automatic write_reg(sesc_pkg::cfg_reg_e idx, logic [39:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // New geometry and threshold, then whole frames with a drained or cut tail
  task automatic run_phase(logic [10:0] cols, logic [11:0] rows, logic [39:0] ksq,
                           int pattern, int nframes);
    int unsigned total, cut;
    logic [15:0] base, px;
    wait_quiet();
    write_reg(sesc_pkg::CFG_COLS, cols);
    write_reg(sesc_pkg::CFG_ROWS, rows);
    write_reg(sesc_pkg::CFG_KSQ, ksq);
    cfg_we <= 1'b0;
    setting_count++;
    for (int f = 0; f < nframes; f++) begin
      total = sb.eff_cols() * sb.eff_rows();
      base = 16'($urandom);
      for (int unsigned i = 0; i < total; i++) begin
        // stray flush inside a frame is ignored, at frame start it eats tail
        if ($urandom_range(0, 99) < 3) send_item(1'b1, '0);
        case (pattern)
          0: px = 16'($urandom);
          1: px = base;
          2: px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: px = base + 16'($urandom_range(0, 1023));
        endcase
        send_item(1'b0, px);
      end
      if (f + 1 < nframes && $urandom_range(0, 3) == 0)
        cut = $urandom_range(0, sb.tail_owed - 1);
      else
        cut = sb.tail_owed + $urandom_range(0, 2);
      repeat (cut) send_item(1'b1, '0);
    end
  endtask

  initial begin
    int unsigned start_items;
    logic [10:0] cols;
    logic [11:0] rows;
    logic [39:0] ksq;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flush with nothing owed, then part of a row at the reset geometry
    send_item(1'b1, '0);
    repeat (12) send_item(1'b0, 16'($urandom));

    // rows wider than the line store clamp to its depth
    wait_quiet();
    write_reg(sesc_pkg::CFG_COLS, 40'd2047);
    write_reg(sesc_pkg::CFG_ROWS, 40'd4);
    cfg_we <= 1'b0;
    setting_count++;
    repeat (12) send_item(1'b0, 16'($urandom));

    // shrink the geometry mid-row and run that frame out
    wait_quiet();
    write_reg(sesc_pkg::CFG_COLS, 40'd4);
    cfg_we <= 1'b0;
    setting_count++;
    while (sb.tail_owed == 0)
      send_item(1'b0, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    repeat (sb.tail_owed + 1) send_item(1'b1, '0);

    // extreme pixels at the reset threshold; the next pixel cuts its tail
    for (int i = 0; i < 16; i++) send_item(1'b0, EDGE_FRAME[i]);
    repeat (2) send_item(1'b1, '0);

    // corner settings: one column, 1x1, zero threshold
    run_phase(11'd0, 12'd40, 40'd1, 0, 1);
    run_phase(11'd0, 12'd0, sesc_pkg::KSQ_RST, 0, 3);
    run_phase(11'd5, 12'd5, 40'd0, 1, 2);
    run_phase(11'd6, 12'd5, 40'd0, 0, 1);

    // full threshold over a long stretch without idling on either side
    calm = 1'b1;
    run_phase(11'd16, 12'd8, 40'hFF_FFFF_FFFF, 3, 1);
    calm = 1'b0;

    // random settings and content
    start_items = sb.live_items;
    while (sb.live_items - start_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0: cols = 11'($urandom_range(0, 3));
        7: cols = 11'($urandom_range(13, 24));
        default: cols = 11'($urandom_range(3, 12));
      endcase
      rows = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 2))
                                         : 12'($urandom_range(3, 8));
      case ($urandom_range(0, 5))
        0: ksq = 40'd1;
        1: ksq = sesc_pkg::KSQ_RST;
        2: ksq = {8'($urandom), 32'($urandom)};
        3: ksq = 40'($urandom_range(1, 1 << 24));
        4: ksq = 40'hFF_FFFF_FFFF;
        default: ksq = 40'($urandom_range(1 << 20, 1 << 30));
      endcase
      run_phase(cols, rows, ksq, $urandom_range(0, 3), $urandom_range(1, 3));
    end
    calm = 1'b0;
    wait_quiet();

    $display("Covered %0d settings and %0d frames: reset geometry, clamped and resized rows,",
             setting_count, sb.frames_done);
    $display("one-column frames, zero threshold, cut tails; %0d items, %0d weights checked.",
             sb.live_items, sb.weights_seen);
    if (sb.mismatches == 0)
      $display("** sobel_edge_stopping_coefficient: PASSED **");
    else
      $display("** sobel_edge_stopping_coefficient: FAILED **");
    $finish;
  end
endmodule
